// ===== hw/rtl/latd_pkg.sv =====
// ----------------------------------------------------------------------------
// latd_pkg: shared types and constants for the task dispatch table
// Field widths of the request and response channels, opcode and sequencer
// state encodings, and parameter defaults.
// ----------------------------------------------------------------------------
package latd_pkg;

   localparam int MAX_TASKS_DEF   = 256;
   localparam int MAX_WORKERS_DEF = 64;

   localparam int OP_W       = 2;
   localparam int CHUNK_W    = 16;
   localparam int LOC_W      = 16;
   localparam int TARGET_W   = 6;
   localparam int WCOUNT_W   = 7;
   localparam int FINCOUNT_W = 8;

   localparam int LOC_BIT_W  = $clog2(LOC_W);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_REQUEST = 2'd1,
      OP_DONE    = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_STORE,
      ST_SCAN,
      ST_TAKE
   } state_type;

endpackage

// ===== hw/rtl/latd_ram.sv =====
// ----------------------------------------------------------------------------
// latd_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module latd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/locality_aware_task_dispatch_unit.sv =====
// ----------------------------------------------------------------------------
// locality_aware_task_dispatch_unit: locality-aware task dispatch table
// Keeps pending tasks in load order; hands a requesting node the oldest task
// that prefers it, else the oldest task of any node, else a finish signal.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+----------------------------
//  request  | req_op, req_chunk_id, req_location,     | start & !busy
//           | req_target_node                         |
//  response | rsp_dispatched .. rsp_workers_finished  | rsp_strobe, one cycle
//  config   | csr_wdata (worker count)                | csr_we, no wait
//
//  Steps per request:
//    load          : bit-serial restoring remainder, one bit a cycle; RAM write
//    request, task : entry scan below the load pointer, one RAM read a cycle,
//                    then the RAM write that retires the picked entry; a node
//                    match ends the scan early
//    request, empty; done report; full-table load; unused opcode : answered in idle
//  Reset is synchronous; it clears counters, the sequencer and the response
//  strobe only and sets the worker count to 1; the table RAM needs no clearing
//  pass since only slots below the load pointer are read.
//  The response is shown for one cycle and cannot be stalled; busy drops in
//  the same cycle, so the next request may be taken while it is out.
// ----------------------------------------------------------------------------
module locality_aware_task_dispatch_unit #(
   parameter int MAX_TASKS   = latd_pkg::MAX_TASKS_DEF,
   parameter int MAX_WORKERS = latd_pkg::MAX_WORKERS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_we,
   input  logic [latd_pkg::WCOUNT_W-1:0]   csr_wdata,
   // request channel
   input  logic                            start,
   output logic                            busy,
   input  logic [latd_pkg::OP_W-1:0]       req_op,
   input  logic [latd_pkg::CHUNK_W-1:0]    req_chunk_id,
   input  logic [latd_pkg::LOC_W-1:0]      req_location,
   input  logic [latd_pkg::TARGET_W-1:0]   req_target_node,
   // response channel
   output logic                            rsp_strobe,
   output logic                            rsp_dispatched,
   output logic [latd_pkg::CHUNK_W-1:0]    rsp_task_chunk,
   output logic [latd_pkg::TARGET_W-1:0]   rsp_task_node,
   output logic                            rsp_finish_signal,
   output logic                            rsp_table_overflow,
   output logic                            rsp_all_map_done,
   output logic [latd_pkg::FINCOUNT_W-1:0] rsp_workers_finished
);

   import latd_pkg::*;

   // counters span 0..MAX_TASKS; slot index spans 0..MAX_TASKS-1
   localparam int PW = $clog2(MAX_TASKS + 1);
   localparam int IW = $clog2(MAX_TASKS);
   // stored node < MAX_WORKERS; effective worker count <= MAX_WORKERS
   localparam int NW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int WW = $clog2(MAX_WORKERS + 1);
   localparam int CW = (NW > TARGET_W) ? NW : TARGET_W;
   // RAM word: {valid, node, chunk}
   localparam int RW = 1 + NW + CHUNK_W;

   localparam logic [PW-1:0]         TASKS_FULL = PW'(MAX_TASKS);
   localparam logic [LOC_BIT_W-1:0]  BIT_LAST   = LOC_BIT_W'(LOC_W - 1);
   localparam logic [FINCOUNT_W-1:0] FIN_SAT    = '1;

   // ---------------------------------------------------------------- registers
   state_type              state_ff, state_in;
   logic [WCOUNT_W-1:0]    wcount_ff;
   logic [PW-1:0]          load_ptr_ff, load_ptr_in;     // also the loaded total
   logic [PW-1:0]          pending_ff, pending_in;
   logic [PW-1:0]          completed_ff, completed_in;
   logic [FINCOUNT_W-1:0]  fin_cnt_ff, fin_cnt_in;

   logic [CHUNK_W-1:0]     chunk_ff, chunk_in;
   logic [LOC_W-1:0]       loc_ff, loc_in;               // shifts out MSB first
   logic [TARGET_W-1:0]    target_ff, target_in;
   logic [NW-1:0]          rem_ff, rem_in;
   logic [LOC_BIT_W-1:0]   bit_cnt_ff, bit_cnt_in;

   logic [PW-1:0]          scan_addr_ff, scan_addr_in;
   logic                   chk_live_ff, chk_live_in;     // RAM data valid this cycle
   logic [IW-1:0]          chk_idx_ff, chk_idx_in;
   logic                   found_ff, found_in;
   logic [IW-1:0]          pick_idx_ff, pick_idx_in;
   logic [CHUNK_W-1:0]     pick_chunk_ff, pick_chunk_in;
   logic [NW-1:0]          pick_node_ff, pick_node_in;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic                   rsp_disp_ff, rsp_disp_in;
   logic [CHUNK_W-1:0]     rsp_chunk_ff, rsp_chunk_in;
   logic [TARGET_W-1:0]    rsp_node_ff, rsp_node_in;
   logic                   rsp_fin_ff, rsp_fin_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;
   logic                   rsp_done_ff, rsp_done_in;
   logic [FINCOUNT_W-1:0]  rsp_wfin_ff, rsp_wfin_in;

   // ---------------------------------------------------------------- RAM
   logic                   ram_we;
   logic [IW-1:0]          ram_waddr;
   logic [RW-1:0]          ram_wdata;
   logic                   ram_re;
   logic [IW-1:0]          ram_raddr;
   logic [RW-1:0]          ram_rdata;

   latd_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   logic                   ent_valid;
   logic [NW-1:0]          ent_node;
   logic [CHUNK_W-1:0]     ent_chunk;
   logic                   ent_match;

   assign ent_valid = ram_rdata[RW-1];
   assign ent_node  = ram_rdata[CHUNK_W +: NW];
   assign ent_chunk = ram_rdata[CHUNK_W-1:0];
   assign ent_match = (CW'(ent_node) == CW'(target_ff));

   // ---------------------------------------------------------------- modulo step
   // worker count 0 acts as 1, above MAX_WORKERS acts as MAX_WORKERS
   logic [8:0]             wc_wide;
   logic [WW-1:0]          eff_workers;
   logic [NW:0]            rem_shift;
   logic [NW:0]            rem_sub;
   logic                   rem_ge;

   assign wc_wide = 9'(wcount_ff);

   always_comb begin
      if (wcount_ff == '0) begin
         eff_workers = WW'(1);
      end else if (wc_wide > 9'(MAX_WORKERS)) begin
         eff_workers = WW'(MAX_WORKERS);
      end else begin
         eff_workers = WW'(wcount_ff);
      end
   end

   assign rem_shift = {rem_ff, loc_ff[LOC_W-1]};
   assign rem_ge    = (rem_shift >= (NW+1)'(eff_workers));
   assign rem_sub   = rem_shift - (NW+1)'(eff_workers);

   // ---------------------------------------------------------------- sequencer
   logic                   emit;
   logic                   map_done;

   always_comb begin
      state_in      = state_ff;
      load_ptr_in   = load_ptr_ff;
      pending_in    = pending_ff;
      completed_in  = completed_ff;
      fin_cnt_in    = fin_cnt_ff;
      chunk_in      = chunk_ff;
      loc_in        = loc_ff;
      target_in     = target_ff;
      rem_in        = rem_ff;
      bit_cnt_in    = bit_cnt_ff;
      scan_addr_in  = scan_addr_ff;
      chk_live_in   = 1'b0;
      chk_idx_in    = chk_idx_ff;
      found_in      = found_ff;
      pick_idx_in   = pick_idx_ff;
      pick_chunk_in = pick_chunk_ff;
      pick_node_in  = pick_node_ff;

      emit          = 1'b0;
      rsp_disp_in   = 1'b0;
      rsp_chunk_in  = '0;
      rsp_node_in   = '0;
      rsp_fin_in    = 1'b0;
      rsp_ovf_in    = 1'b0;

      ram_we        = 1'b0;
      ram_waddr     = pick_idx_ff;
      ram_wdata     = {1'b0, pick_node_ff, pick_chunk_ff};
      ram_re        = 1'b0;
      ram_raddr     = scan_addr_ff[IW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               chunk_in  = req_chunk_id;
               loc_in    = req_location;
               target_in = req_target_node;
               case (req_op)
                  OP_LOAD: begin
                     if (load_ptr_ff == TASKS_FULL) begin
                        emit       = 1'b1;
                        rsp_ovf_in = 1'b1;
                     end else begin
                        rem_in     = '0;
                        bit_cnt_in = '0;
                        state_in   = ST_MOD;
                     end
                  end
                  OP_REQUEST: begin
                     if (pending_ff == '0) begin
                        emit       = 1'b1;
                        rsp_fin_in = 1'b1;
                        if (fin_cnt_ff != FIN_SAT) begin
                           fin_cnt_in = fin_cnt_ff + 1'b1;
                        end
                     end else begin
                        scan_addr_in = '0;
                        found_in     = 1'b0;
                        state_in     = ST_SCAN;
                     end
                  end
                  OP_DONE: begin
                     emit = 1'b1;
                     if (completed_ff != TASKS_FULL) begin
                        completed_in = completed_ff + 1'b1;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end

         // restoring remainder, one location bit a cycle
         ST_MOD: begin
            rem_in     = rem_ge ? rem_sub[NW-1:0] : rem_shift[NW-1:0];
            loc_in     = {loc_ff[LOC_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_LAST) begin
               state_in = ST_STORE;
            end
         end

         ST_STORE: begin
            ram_we      = 1'b1;
            ram_waddr   = load_ptr_ff[IW-1:0];
            ram_wdata   = {1'b1, rem_ff, chunk_ff};
            load_ptr_in = load_ptr_ff + 1'b1;
            pending_in  = pending_ff + 1'b1;
            emit        = 1'b1;
            state_in    = ST_IDLE;
         end

         // stream reads over slots below the load pointer; check one a cycle
         ST_SCAN: begin
            ram_re = (scan_addr_ff < load_ptr_ff);
            if (ram_re) begin
               scan_addr_in = scan_addr_ff + 1'b1;
               chk_live_in  = 1'b1;
               chk_idx_in   = scan_addr_ff[IW-1:0];
            end
            if (chk_live_ff && ent_valid && (ent_match || !found_ff)) begin
               found_in      = 1'b1;
               pick_idx_in   = chk_idx_ff;
               pick_chunk_in = ent_chunk;
               pick_node_in  = ent_node;
            end
            if ((chk_live_ff && ent_valid && ent_match) || !ram_re) begin
               chk_live_in = 1'b0;
               state_in    = ST_TAKE;
            end
         end

         // retire the picked slot and hand it out
         ST_TAKE: begin
            ram_we       = 1'b1;
            pending_in   = pending_ff - 1'b1;
            emit         = 1'b1;
            rsp_disp_in  = 1'b1;
            rsp_chunk_in = pick_chunk_ff;
            rsp_node_in  = TARGET_W'(pick_node_ff);
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      map_done = (pending_in == '0) && (completed_in >= load_ptr_in);

      rsp_strobe_in = emit;
      rsp_done_in   = emit ? map_done : rsp_done_ff;
      rsp_wfin_in   = emit ? fin_cnt_in : rsp_wfin_ff;
      if (!emit) begin
         rsp_disp_in  = rsp_disp_ff;
         rsp_chunk_in = rsp_chunk_ff;
         rsp_node_in  = rsp_node_ff;
         rsp_fin_in   = rsp_fin_ff;
         rsp_ovf_in   = rsp_ovf_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wcount_ff     <= WCOUNT_W'(1);
         load_ptr_ff   <= '0;
         pending_ff    <= '0;
         completed_ff  <= '0;
         fin_cnt_ff    <= '0;
         chk_live_ff   <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_we) begin
            wcount_ff  <= csr_wdata;
         end
         load_ptr_ff   <= load_ptr_in;
         pending_ff    <= pending_in;
         completed_ff  <= completed_in;
         fin_cnt_ff    <= fin_cnt_in;
         chk_live_ff   <= chk_live_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      chunk_ff      <= chunk_in;
      loc_ff        <= loc_in;
      target_ff     <= target_in;
      rem_ff        <= rem_in;
      bit_cnt_ff    <= bit_cnt_in;
      scan_addr_ff  <= scan_addr_in;
      chk_idx_ff    <= chk_idx_in;
      pick_idx_ff   <= pick_idx_in;
      pick_chunk_ff <= pick_chunk_in;
      pick_node_ff  <= pick_node_in;
      rsp_disp_ff   <= rsp_disp_in;
      rsp_chunk_ff  <= rsp_chunk_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_fin_ff    <= rsp_fin_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_wfin_ff   <= rsp_wfin_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_dispatched       = rsp_disp_ff;
   assign rsp_task_chunk       = rsp_chunk_ff;
   assign rsp_task_node        = rsp_node_ff;
   assign rsp_finish_signal    = rsp_fin_ff;
   assign rsp_table_overflow   = rsp_ovf_ff;
   assign rsp_all_map_done     = rsp_done_ff;
   assign rsp_workers_finished = rsp_wfin_ff;

endmodule
